/* src/ngis_pkg.sv */
// Shared types, constants and register codes for the N-gap interval splitter.
package ngis_pkg;

  // Width of the position counters; outputs keep the low 32 bits.
  localparam int unsigned POS_BITS = 32;
  // Width wide enough to compare a position difference with a 32-bit length.
  localparam int unsigned CMP_W    = (POS_BITS > 32) ? POS_BITS : 32;

  // Depth of the queue between front and back (a power of two).
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [CMP_W-1:0]    cmp_t;
  typedef logic [31:0]         word_t;
  typedef logic [15:0]         run_t;
  typedef logic [QPTR_W-1:0]   qptr_t;
  typedef logic [QPTR_W:0]     qcnt_t;

  localparam logic [7:0] CHAR_N_UP     = 8'h4E;
  localparam logic [7:0] CHAR_N_LO     = 8'h6E;
  localparam run_t       GAP_RUN_RST   = 16'd10;
  localparam word_t      PIECE_LEN_RST = 32'd100;
  localparam pos_t       POS_ONE       = pos_t'(1);
  localparam run_t       RUN_ONE       = 16'd1;

  typedef enum logic {
    REG_MIN_GAP_RUN   = 1'b0,
    REG_MIN_PIECE_LEN = 1'b1
  } cfg_reg_e;

  // One reported interval.
  typedef struct packed {
    word_t first_pos;
    word_t length;
    logic  last;
  } result_t;

  // Results caused by one base; res0 always valid, res1 valid when two is set.
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } entry_t;

endpackage

/* src/ngis_front.sv */
// Front end: config registers, gap tracking and interval classification per base.
module ngis_front import ngis_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  word_t      cfg_data_i,
  input  logic       push_i,
  input  logic [7:0] base_i,
  input  logic       seq_end_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output entry_t     q_entry_o
);

  run_t  min_gap_q;
  word_t min_piece_q;
  pos_t  position_q, position_d;
  pos_t  run_start_q, run_start_d;
  run_t  run_count_q, run_count_d;
  pos_t  piece_start_q, piece_start_d;
  logic  in_gap_q, in_gap_d;

  logic    accept;
  logic    is_n;
  logic    gap_hit;
  run_t    thresh;
  pos_t    pos;
  pos_t    len_gap;
  pos_t    len_tail;
  logic    a_v, b_v;
  result_t a_res, b_res;

  // Write config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q   <= GAP_RUN_RST;
      min_piece_q <= PIECE_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_GAP_RUN:   min_gap_q   <= cfg_data_i[15:0];
        REG_MIN_PIECE_LEN: min_piece_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = push_i && !q_full_i;

  // Classify the base and work out the results it causes
  always_comb begin
    thresh        = (min_gap_q == '0) ? RUN_ONE : min_gap_q;
    pos           = position_q + POS_ONE;
    is_n          = (base_i == CHAR_N_UP) || (base_i == CHAR_N_LO);
    run_start_d   = run_start_q;
    run_count_d   = run_count_q;
    piece_start_d = piece_start_q;
    in_gap_d      = in_gap_q;
    gap_hit       = 1'b0;
    a_v           = 1'b0;
    b_v           = 1'b0;
    a_res         = '0;
    b_res         = '0;

    if (is_n) begin
      if (run_count_q == '0) begin
        run_start_d = pos;
        run_count_d = RUN_ONE;
      end else if (run_count_q < thresh) begin
        run_count_d = run_count_q + RUN_ONE;
      end
      gap_hit = !in_gap_q && (run_count_d >= thresh);
      if (gap_hit) begin
        in_gap_d = 1'b1;
      end
    end else begin
      run_count_d = '0;
      if (in_gap_q) begin
        in_gap_d      = 1'b0;
        piece_start_d = pos;
      end
    end

    // Interval closed by a new gap
    len_gap = run_start_d - piece_start_q;
    if (gap_hit) begin
      if (run_start_d == POS_ONE) begin
        a_v   = 1'b1;
        a_res = '{first_pos: 32'd1, length: 32'd1, last: 1'b0};
      end else if ((cmp_t'(len_gap) >= cmp_t'(min_piece_q)) ||
                   (piece_start_q == POS_ONE)) begin
        a_v   = 1'b1;
        a_res = '{first_pos: word_t'(piece_start_q), length: word_t'(len_gap), last: 1'b0};
      end
    end

    // Close the sequence on its last base
    len_tail = pos - piece_start_d + POS_ONE;
    if (seq_end_i) begin
      if (in_gap_d) begin
        if (pos != POS_ONE) begin
          b_v   = 1'b1;
          b_res = '{first_pos: word_t'(pos), length: 32'd1, last: 1'b1};
        end else if (a_v) begin
          a_res.last = 1'b1;
        end else begin
          b_v   = 1'b1;
          b_res = '{first_pos: 32'd1, length: 32'd1, last: 1'b1};
        end
      end else begin
        b_v   = 1'b1;
        b_res = '{first_pos: word_t'(piece_start_d), length: word_t'(len_tail), last: 1'b1};
      end
    end

    if (seq_end_i) begin
      position_d    = '0;
      run_start_d   = '0;
      run_count_d   = '0;
      piece_start_d = POS_ONE;
      in_gap_d      = 1'b0;
    end else begin
      position_d    = pos;
    end
  end

  // Advance sequence state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= '0;
      run_start_q   <= '0;
      run_count_q   <= '0;
      piece_start_q <= POS_ONE;
      in_gap_q      <= 1'b0;
    end else if (accept) begin
      position_q    <= position_d;
      run_start_q   <= run_start_d;
      run_count_q   <= run_count_d;
      piece_start_q <= piece_start_d;
      in_gap_q      <= in_gap_d;
    end
  end

  // Pack the results; drop bases that report nothing
  assign q_push_o       = accept && (a_v || b_v);
  assign q_entry_o.two  = a_v && b_v;
  assign q_entry_o.res0 = a_v ? a_res : b_res;
  assign q_entry_o.res1 = b_res;

endmodule

/* src/ngis_queue.sv */
// Short queue of result entries between the front and the back.
module ngis_queue import ngis_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  entry_t mem_q [QDEPTH];
  qptr_t  wr_ptr_q;
  qptr_t  rd_ptr_q;
  qcnt_t  count_q;
  logic   do_push;
  logic   do_pop;

  assign full_o  = (count_q == qcnt_t'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Store incoming entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + qptr_t'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + qptr_t'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + qcnt_t'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - qcnt_t'(1);
      end
    end
  end

endmodule

/* src/ngis_back.sv */
// Back end: splits entries into single result words behind an output register.
module ngis_back import ngis_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  entry_t  q_entry_i,
  output logic    q_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t out_o
);

  result_t out_q;
  result_t pend_q;
  logic    out_valid_q;
  logic    pend_valid_q;
  logic    out_free;

  assign out_free = !out_valid_q || pop_i;
  assign q_pop_o  = q_valid_i && !pend_valid_q && out_free;
  assign empty_o  = !out_valid_q;
  assign out_o    = out_q;

  // Load the output word from the pending slot or a fresh entry
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
      end else if (q_valid_i) begin
        out_q  <= q_entry_i.res0;
        pend_q <= q_entry_i.res1;
      end
    end
  end

  // Track which slots hold a word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (out_free) begin
      if (pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (q_valid_i) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= q_entry_i.two;
      end else begin
        out_valid_q  <= 1'b0;
      end
    end
  end

endmodule

/* src/n_gap_interval_splitter_top.sv */
// Top level of the N-gap interval splitter: front, queue and back.
// A base that reports an interval enters the queue on the edge that accepts it, is shown
//   once the output register is free; a second one from that base follows one word later.
// Throughput: one base per cycle unless full; one word out per cycle while pop is high.
// The four-entry queue between front and back absorbs bases that report two words.
// Reset: asynchronous, active low; sequence state cleared, registers return to 10 and 100.
module n_gap_interval_splitter_top import ngis_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  base_i,
  input  logic        seq_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] first_pos_o,
  output logic [31:0] length_o,
  output logic        last_of_seq_o
);

  logic    q_push;
  entry_t  q_entry_in;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  entry_t  q_entry_out;
  result_t out_word;

  ngis_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .base_i     (base_i),
    .seq_end_i  (seq_end_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry_in)
  );

  ngis_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry_out)
  );

  ngis_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry_out),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_o     (out_word)
  );

  assign full          = q_full;
  assign first_pos_o   = out_word.first_pos;
  assign length_o      = out_word.length;
  assign last_of_seq_o = out_word.last;

endmodule

/* src/ngis_checker.sv */
// Port-level checker for the N-gap interval splitter, bound to the top level.
module ngis_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [0:0]  cfg_idx_i,
  input logic [31:0] cfg_data_i,
  input logic        push,
  input logic        full,
  input logic [7:0]  base_i,
  input logic        seq_end_i,
  input logic        empty,
  input logic        pop,
  input logic [31:0] first_pos_o,
  input logic [31:0] length_o,
  input logic        last_of_seq_o
);

  // Come out of reset with nothing buffered and room for input
  a_reset_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty && !full)
    else $error("not empty or full right after reset");

  // Hold a waiting word until it is taken
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(first_pos_o) && $stable(length_o) &&
                       $stable(last_of_seq_o))
    else $error("waiting result word changed or vanished");

  // With no input word accepted just before or while the output is empty, nothing is buffered
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !full) ##1 (empty && !(push && !full)) |=> empty)
    else $error("result word appeared without a recent input word");

  // Keep the fields of an offered input word known
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !$isunknown({base_i, seq_end_i}))
    else $error("unknown input word fields while pushing");

  // Keep register index and data known on a write
  a_cfg_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !$isunknown({cfg_idx_i, cfg_data_i}))
    else $error("unknown register index or data on a write");

endmodule

bind n_gap_interval_splitter_top ngis_checker u_ngis_checker (.*);

/* dv/tb_n_gap_interval_splitter_top.sv */
// Self-checking testbench for the N-gap interval splitter: directed table, then random sequences.
`timescale 1ns / 100ps

module tb_n_gap_interval_splitter_top;
  import ngis_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 175;
  localparam int SETTLE_WAIT  = 4;
  localparam int DRAIN_LIMIT  = 20000;

  typedef enum logic [1:0] {ROW_BASE, ROW_KNOWN, ROW_CFG} row_kind_e;

  // One line of the directed table.
  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] b;
    logic       e;
    result_t    want;
    cfg_reg_e   idx;
    word_t      data;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        push;
  logic        full;
  logic [7:0]  base_i;
  logic        seq_end_i;
  logic        empty;
  logic        pop;
  logic [31:0] first_pos_o;
  logic [31:0] length_o;
  logic        last_of_seq_o;

  n_gap_interval_splitter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .base_i       (base_i),
    .seq_end_i    (seq_end_i),
    .empty        (empty),
    .pop          (pop),
    .first_pos_o  (first_pos_o),
    .length_o     (length_o),
    .last_of_seq_o(last_of_seq_o)
  );

  // Splitter state and register copies
  run_t    gap_thresh;
  word_t   piece_min;
  pos_t    cur_pos;
  pos_t    run_begin;
  run_t    run_len;
  pos_t    piece_begin;
  logic    gap_open;
  result_t step_res [2];

  result_t   interval_q [$];
  stim_row_t dir_rows [$];

  int  errors = 0;
  int  bases_sent = 0;
  int  intervals_seen = 0;
  int  reg_writes = 0;
  int  burst_left = 1;
  bit  hold_req = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic result_t interval(input pos_t s, input pos_t l, input logic last);
    result_t r;
    r.first_pos = word_t'(s);
    r.length    = word_t'(l);
    r.last      = last;
    return r;
  endfunction

  function automatic void clear_seq();
    cur_pos     = '0;
    run_begin   = '0;
    run_len     = '0;
    piece_begin = POS_ONE;
    gap_open    = 1'b0;
  endfunction

  // Advance the splitter by one base; fill step_res and return how many intervals it gives.
  function automatic int split_step(input logic [7:0] b, input logic e);
    run_t thr;
    pos_t len;
    int   n;
    thr = (gap_thresh == '0) ? RUN_ONE : gap_thresh;
    n = 0;
    cur_pos = cur_pos + POS_ONE;
    if (b == CHAR_N_UP || b == CHAR_N_LO) begin
      if (run_len == '0) begin
        run_begin = cur_pos;
        run_len   = RUN_ONE;
      end else if (run_len < thr) begin
        run_len = run_len + RUN_ONE;
      end
      // report the piece in front of a run that just became a gap
      if (!gap_open && run_len >= thr) begin
        gap_open = 1'b1;
        if (run_begin == POS_ONE) begin
          step_res[n] = interval(POS_ONE, POS_ONE, 1'b0);
          n++;
        end else begin
          len = run_begin - piece_begin;
          if (cmp_t'(len) >= cmp_t'(piece_min) || piece_begin == POS_ONE) begin
            step_res[n] = interval(piece_begin, len, 1'b0);
            n++;
          end
        end
      end
    end else begin
      run_len = '0;
      if (gap_open) begin
        gap_open    = 1'b0;
        piece_begin = cur_pos;
      end
    end
    // close the sequence
    if (e) begin
      if (gap_open) begin
        if (cur_pos != POS_ONE) begin
          step_res[n] = interval(cur_pos, POS_ONE, 1'b1);
          n++;
        end else if (n > 0) begin
          step_res[n-1].last = 1'b1;
        end else begin
          step_res[n] = interval(POS_ONE, POS_ONE, 1'b1);
          n++;
        end
      end else begin
        len = cur_pos - piece_begin + POS_ONE;
        step_res[n] = interval(piece_begin, len, 1'b1);
        n++;
      end
      clear_seq();
    end
    return n;
  endfunction

  // Directed table builders
  function automatic void add_base(input logic [7:0] b, input logic e);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BASE;
    r.b    = b;
    r.e    = e;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_known(input logic [7:0] b, input logic e, input pos_t s,
                                    input pos_t l, input logic last);
    stim_row_t r;
    r = '0;
    r.kind = ROW_KNOWN;
    r.b    = b;
    r.e    = e;
    r.want = interval(s, l, last);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_cfg(input cfg_reg_e idx, input word_t data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Offer one word and wait for it to be taken; then pace the next one.
  task automatic offer(input logic [7:0] b, input logic e, input logic known,
                       input result_t want);
    int n;
    int gap;
    int r;
    push      <= 1'b1;
    base_i    <= b;
    seq_end_i <= e;
    do @(posedge clk_i); while (full);
    n = split_step(b, e);
    if (known) begin
      interval_q.insert(interval_q.size(), want);
    end else begin
      for (int i = 0; i < n; i++) interval_q.insert(interval_q.size(), step_res[i]);
    end
    bases_sent++;
    // bursts of random length, random gaps between them
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      r = $urandom_range(0, 9);
      if (r < 4) gap = 0;
      else if (r < 9) gap = $urandom_range(1, 5);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold the input until every expected interval is out, then let the pipeline empty.
  task automatic settle();
    push <= 1'b0;
    while (interval_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_reg_e idx, input word_t data);
    if (idx == REG_MIN_GAP_RUN) gap_thresh = data[15:0];
    else piece_min = data;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  function automatic logic [7:0] pick_plain();
    string acgt;
    acgt = "ACGTacgt";
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return acgt[$urandom_range(0, 7)];
  endfunction

  // Build one random sequence of plain pieces and N runs sized around the settings.
  task automatic send_sequence();
    logic [7:0] seq_buf [$];
    int segs;
    int thr_gen;
    int pm_gen;
    int len;
    int r;
    bit in_run;
    thr_gen = (gap_thresh == '0) ? 1 : ((gap_thresh > 24) ? 24 : int'(gap_thresh));
    pm_gen  = (piece_min > 120) ? 120 : int'(piece_min);
    if ($urandom_range(0, 7) == 0) begin
      // noise
      len = $urandom_range(1, 20);
      repeat (len) seq_buf.insert(seq_buf.size(), 8'($urandom));
    end else begin
      segs   = $urandom_range(1, 5);
      in_run = ($urandom_range(0, 2) == 0);
      repeat (segs) begin
        if (in_run) begin
          r = $urandom_range(0, 3);
          if (r == 0) len = (thr_gen > 1) ? thr_gen - 1 : 1;
          else if (r == 1) len = thr_gen;
          else if (r == 2) len = thr_gen + $urandom_range(1, 3);
          else len = $urandom_range(1, thr_gen);
          repeat (len) seq_buf.insert(seq_buf.size(),
                                      $urandom_range(0, 1) ? CHAR_N_UP : CHAR_N_LO);
        end else begin
          r = $urandom_range(0, 5);
          if (r < 3) len = $urandom_range(1, 12);
          else if (r == 3) len = pm_gen + $urandom_range(0, 2) - 1;
          else if (r == 4) len = $urandom_range(1, pm_gen + 3);
          else len = 1;
          if (len < 1) len = 1;
          repeat (len) seq_buf.insert(seq_buf.size(), pick_plain());
        end
        in_run = !in_run;
      end
    end
    foreach (seq_buf[i]) offer(seq_buf[i], (i == seq_buf.size() - 1), 1'b0, '0);
  endtask

  // Receiver: check each popped word, stall on a pattern, hold off on request.
  initial begin
    result_t    want;
    logic [15:0] pat;
    logic [3:0]  pat_idx;
    int          hold_left;
    pop       = 1'b0;
    pat       = '1;
    pat_idx   = '0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        intervals_seen++;
        if (interval_q.size() == 0) begin
          $error("unexpected interval: first_pos %0d length %0d last_of_seq %0d",
                 first_pos_o, length_o, last_of_seq_o);
          errors++;
        end else begin
          want = interval_q.pop_front();
          if (first_pos_o !== want.first_pos) begin
            $error("first_pos: expected %0d, got %0d", want.first_pos, first_pos_o);
            errors++;
          end
          if (length_o !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, length_o);
            errors++;
          end
          if (last_of_seq_o !== want.last) begin
            $error("last_of_seq: expected %0d, got %0d", want.last, last_of_seq_o);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        if (pat_idx == '0) pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        pop <= pat[pat_idx];
        pat_idx = pat_idx + 4'd1;
      end
    end
  end

  // Sender: reset, directed table, random phases, drain.
  initial begin
    int    waited;
    int    phase_start;
    run_t  gap_val;
    word_t piece_val;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    push       = 1'b0;
    base_i     = '0;
    seq_end_i  = 1'b0;
    gap_thresh = GAP_RUN_RST;
    piece_min  = PIECE_LEN_RST;
    clear_seq();

    // after reset: single-base sequences, one interval each
    add_known("A",   1'b1, 1, 1, 1'b1);
    add_known(8'hFF, 1'b1, 1, 1, 1'b1);
    add_known(8'h00, 1'b1, 1, 1, 1'b1);
    add_known("N",   1'b1, 1, 1, 1'b1);
    // smallest gap, keep every piece: all-N sequences, gap inside
    add_cfg(REG_MIN_GAP_RUN, 32'd1);
    add_cfg(REG_MIN_PIECE_LEN, 32'd0);
    add_base("n", 1'b1);
    add_base("N", 1'b0);
    add_base("N", 1'b1);
    add_base("A", 1'b0);
    add_base("N", 1'b0);
    add_base("C", 1'b1);
    // short interior piece dropped, boundary-length piece kept
    add_cfg(REG_MIN_GAP_RUN, 32'd2);
    add_cfg(REG_MIN_PIECE_LEN, 32'd3);
    add_base("A", 1'b0);
    add_base("N", 1'b0);
    add_base("N", 1'b0);
    add_base("C", 1'b0);
    add_base("N", 1'b0);
    add_base("n", 1'b0);
    add_base("G", 1'b0);
    add_base("G", 1'b0);
    add_base("g", 1'b0);
    add_base("N", 1'b0);
    add_base("N", 1'b0);
    add_base("T", 1'b1);
    // threshold lowered mid-run, to zero with junk in the upper half
    add_cfg(REG_MIN_GAP_RUN, 32'd5);
    add_base("N", 1'b0);
    add_base("N", 1'b0);
    add_base("N", 1'b0);
    add_cfg(REG_MIN_GAP_RUN, 32'hFFFF_0000);
    add_base("N", 1'b0);
    add_base("A", 1'b1);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          settle();
          set_reg(dir_rows[i].idx, dir_rows[i].data);
        end
        ROW_KNOWN: offer(dir_rows[i].b, dir_rows[i].e, 1'b1, dir_rows[i].want);
        default: offer(dir_rows[i].b, dir_rows[i].e, 1'b0, '0);
      endcase
    end

    // random phases, each under its own settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin gap_val = 16'd1;     piece_val = 32'd0;                  end
        1: begin gap_val = 16'd2;     piece_val = $urandom_range(0, 8);   end
        2: begin gap_val = 16'd3;     piece_val = 32'hFFFF_FFFF;          end
        3: begin gap_val = GAP_RUN_RST; piece_val = PIECE_LEN_RST;        end
        4: begin gap_val = 16'($urandom_range(1, 12)); piece_val = $urandom_range(0, 30); end
        5: begin gap_val = 16'hFFFF;  piece_val = $urandom_range(0, 20);  end
        6: begin gap_val = 16'd0;     piece_val = 32'd1;                  end
        default: begin gap_val = 16'($urandom_range(1, 6)); piece_val = $urandom_range(0, 15); end
      endcase
      settle();
      set_reg(REG_MIN_GAP_RUN, {16'($urandom), gap_val});
      set_reg(REG_MIN_PIECE_LEN, piece_val);
      // stall the output for a long stretch while bases keep coming
      if (ph == 1 || ph == 5) hold_req = 1'b1;
      phase_start = bases_sent;
      while (bases_sent - phase_start < PHASE_ITEMS) send_sequence();
      // leave a run open across the next settings change now and then
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 6)) offer(CHAR_N_UP, 1'b0, 1'b0, '0);
      end
    end

    // drain
    push <= 1'b0;
    waited = 0;
    while (interval_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (interval_q.size() != 0) begin
      $error("%0d expected intervals never arrived", interval_q.size());
      errors += interval_q.size();
    end
    repeat (10) @(posedge clk_i);

    $display("Summary: %0d bases over %0d register writes, %0d intervals compared",
             bases_sent, reg_writes, intervals_seen);
    $display("Settings swept gap runs 0 to 65535 and piece lengths 0 to 2^32-1, with stalls");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
